### sv/mrp_pkg.sv
// shared constants and arithmetic helpers for the vector rotation unit
package mrp_pkg;

    // fixed field widths
    localparam int ROT_W         = 18;
    localparam int VEC_W         = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_BITS     = 30;

    // reciprocal divider: denominator width and quotient bits
    localparam int DEN_W = 54;
    localparam int Q_W   = 31;

    // working width of the rounding helper
    localparam int ACC_W = 104;

    // rounded arithmetic right shift, ties away from zero
    function automatic logic signed [ACC_W-1:0] rnd_shift(
        input logic signed [ACC_W-1:0] p,
        input int unsigned             k
    );
        logic signed [ACC_W-1:0] h;
        h = '0;
        h[k-1] = 1'b1;
        if (p < 0) begin
            rnd_shift = (p + h - ACC_W'(1)) >>> k;
        end else begin
            rnd_shift = (p + h) >>> k;
        end
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            sat32 = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

endpackage

### sv/mrp_vector_rotation_unit.sv
// top level: fixed-point vector rotation by a modified Rodrigues vector
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+----------------------------------------
//  input   | i_in_valid  | o_in_stall  | i_rot_x/y/z, i_vec_x/y/z
//  output  | o_out_valid | i_out_stall | o_out_x/y/z
//
// one beat in per cycle and one beat out per cycle while the output is not stalled;
// stages: 2 front stages, 31 stages of the reciprocal divider, 7 back stages
// the divider forming 1/(1+|t|^2) one quotient bit per stage sets the depth
// each stage advances when it is empty or the stage after it advances,
// so bubbles close up behind a stalled output
// synchronous active-low reset clears the valid bits only
module mrp_vector_rotation_unit #(
    parameter int FRAC_BITS = mrp_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [mrp_pkg::ROT_W-1:0]  i_rot_x,
    input  logic signed [mrp_pkg::ROT_W-1:0]  i_rot_y,
    input  logic signed [mrp_pkg::ROT_W-1:0]  i_rot_z,
    input  logic signed [mrp_pkg::VEC_W-1:0]  i_vec_x,
    input  logic signed [mrp_pkg::VEC_W-1:0]  i_vec_y,
    input  logic signed [mrp_pkg::VEC_W-1:0]  i_vec_z,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [mrp_pkg::VEC_W-1:0]  o_out_x,
    output logic signed [mrp_pkg::VEC_W-1:0]  o_out_y,
    output logic signed [mrp_pkg::VEC_W-1:0]  o_out_z
);

    localparam int RW   = mrp_pkg::ROT_W;
    localparam int VW   = mrp_pkg::VEC_W;
    localparam int NQ   = mrp_pkg::Q_W;
    localparam int DW   = mrp_pkg::DEN_W;
    localparam int AW   = mrp_pkg::ACC_W;
    localparam int CB   = mrp_pkg::COEF_BITS;
    localparam int NS   = NQ + 9;
    localparam int ST_D = 2;
    localparam int ST_E = NQ + 2;
    localparam int PAYW = 3 * RW + 3 * VW;

    // squared-norm scaling to 32 fraction bits
    localparam int LSH = (2 * FRAC_BITS <= 32) ? 32 - 2 * FRAC_BITS : 0;
    localparam int RSH = (2 * FRAC_BITS > 32) ? 2 * FRAC_BITS - 32 : 0;
    localparam int RHB = (RSH > 0) ? RSH - 1 : 0;
    localparam logic [36:0] RHALF = (RSH > 0) ? (37'd1 << RHB) : 37'd0;
    localparam logic [61:0] WHALF = 62'd1 << (CB - 1);

    // product widths
    localparam int BTW  = 36 + RW - FRAC_BITS + 1;
    localparam int BPLW = BTW + 27;
    localparam int BPHW = BTW + 26;
    localparam int BPW  = BTW + 52;

    // stage control
    logic [NS-1:0] r_vld;
    logic [NS-1:0] stage_en;

    always_comb begin
        stage_en[NS-1] = !r_vld[NS-1] || !i_out_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign o_in_stall  = !stage_en[0];
    assign o_out_valid = r_vld[NS-1];

    // stage 0: capture and square the rotation vector
    logic signed [RW-1:0] in_t [3];
    logic signed [VW-1:0] in_v [3];
    logic signed [35:0]   sq   [3];
    logic        [34:0]   r0_sq [3];
    logic signed [RW-1:0] r0_t  [3];
    logic signed [VW-1:0] r0_v  [3];

    assign in_t[0] = i_rot_x;
    assign in_t[1] = i_rot_y;
    assign in_t[2] = i_rot_z;
    assign in_v[0] = i_vec_x;
    assign in_v[1] = i_vec_y;
    assign in_v[2] = i_vec_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq[i] = 36'(in_t[i]) * 36'(in_t[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r0_sq[i] <= sq[i][34:0];
                r0_t[i]  <= in_t[i];
                r0_v[i]  <= in_v[i];
            end
        end
    end

    // stage 1: denominator 1+s and the divider start
    logic [35:0]          n_s;
    logic [DW-1:0]        n_den;
    logic [DW-1:0]        r1_den;
    logic [DW-1:0]        r1_rem;
    logic [NQ-1:0]        r1_nlow;
    logic signed [RW-1:0] r1_t [3];
    logic signed [VW-1:0] r1_v [3];

    always_comb begin
        n_s   = 36'(r0_sq[0]) + 36'(r0_sq[1]) + 36'(r0_sq[2]);
        n_den = (DW'(37'(37'(n_s) + RHALF) >> RSH) << LSH) + (DW'(1) << 32);
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r1_den  <= n_den;
            r1_rem  <= (DW'(1) << 31) + (n_den >> 32);
            r1_nlow <= n_den[NQ:1];
            r1_t    <= r0_t;
            r1_v    <= r0_v;
        end
    end

    // stages 2 to 32: w = 1/(1+s) in Q.30
    logic [PAYW-1:0] div_pay_in;
    logic [PAYW-1:0] div_pay_out;
    logic [NQ-1:0]   div_quo;

    assign div_pay_in = {r1_t[0], r1_t[1], r1_t[2], r1_v[0], r1_v[1], r1_v[2]};

    mrp_div #(
        .PW (PAYW)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (stage_en[ST_D +: NQ]),
        .i_den  (r1_den),
        .i_rem  (r1_rem),
        .i_nlow (r1_nlow),
        .i_pay  (div_pay_in),
        .o_quo  (div_quo),
        .o_pay  (div_pay_out)
    );

    // back stage 0: w squared and the dot and cross partial products
    logic signed [RW-1:0] dv_t [3];
    logic signed [VW-1:0] dv_v [3];
    logic [NQ-1:0]        r2_w;
    logic [61:0]          r2_ww;
    logic signed [49:0]   r2_tv [3][3];
    logic signed [RW-1:0] r2_t [3];
    logic signed [VW-1:0] r2_v [3];

    assign dv_t[0] = div_pay_out[PAYW-1 -: RW];
    assign dv_t[1] = div_pay_out[PAYW-RW-1 -: RW];
    assign dv_t[2] = div_pay_out[PAYW-2*RW-1 -: RW];
    assign dv_v[0] = div_pay_out[3*VW-1 -: VW];
    assign dv_v[1] = div_pay_out[2*VW-1 -: VW];
    assign dv_v[2] = div_pay_out[VW-1:0];

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_E]) begin
            r2_w  <= div_quo;
            r2_ww <= 62'(div_quo) * 62'(div_quo);
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r2_tv[i][j] <= 50'(dv_t[i]) * 50'(dv_v[j]);
                end
            end
            r2_t <= dv_t;
            r2_v <= dv_v;
        end
    end

    // back stage 1: coefficients A, C, 8w^2 and the dot and cross products
    logic [NQ-1:0]        n_w2;
    logic signed [35:0]   n_bw;
    logic signed [35:0]   r3_a;
    logic signed [35:0]   r3_c;
    logic signed [35:0]   r3_bw;
    logic signed [51:0]   r3_p;
    logic signed [51:0]   r3_x [3];
    logic signed [RW-1:0] r3_t [3];
    logic signed [VW-1:0] r3_v [3];

    always_comb begin
        n_w2 = NQ'((r2_ww + WHALF) >> CB);
        n_bw = $signed({2'b00, n_w2, 3'b000});
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_E+1]) begin
            r3_bw   <= n_bw;
            r3_a    <= n_bw - $signed({2'b00, r2_w, 3'b000}) + (36'sd1 <<< CB);
            r3_c    <= n_bw - $signed({3'b000, r2_w, 2'b00});
            r3_p    <= 52'(r2_tv[0][0]) + 52'(r2_tv[1][1]) + 52'(r2_tv[2][2]);
            r3_x[0] <= 52'(r2_tv[1][2]) - 52'(r2_tv[2][1]);
            r3_x[1] <= 52'(r2_tv[2][0]) - 52'(r2_tv[0][2]);
            r3_x[2] <= 52'(r2_tv[0][1]) - 52'(r2_tv[1][0]);
            r3_t    <= r2_t;
            r3_v    <= r2_v;
        end
    end

    // back stage 2: coefficient products, cross product split in halves
    logic signed [53:0] r4_btp [3];
    logic signed [67:0] r4_av  [3];
    logic signed [62:0] r4_cxl [3];
    logic signed [61:0] r4_cxh [3];
    logic signed [51:0] r4_p;

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_E+2]) begin
            for (int i = 0; i < 3; i++) begin
                r4_btp[i] <= 54'(r3_bw) * 54'(r3_t[i]);
                r4_av[i]  <= 68'(r3_a) * 68'(r3_v[i]);
                r4_cxl[i] <= 63'(r3_c) * 63'($signed({1'b0, r3_x[i][25:0]}));
                r4_cxh[i] <= 62'(r3_c) * 62'($signed(r3_x[i][51:26]));
            end
            r4_p <= r3_p;
        end
    end

    // back stage 3: round B*t and A*v, join the cross halves
    logic signed [AW-1:0]  n_bt [3];
    logic signed [AW-1:0]  n_ta [3];
    logic signed [BTW-1:0] r5_bt [3];
    logic signed [61:0]    r5_ta [3];
    logic signed [87:0]    r5_cx [3];
    logic signed [51:0]    r5_p;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_bt[i] = mrp_pkg::rnd_shift(AW'(r4_btp[i]), FRAC_BITS);
            n_ta[i] = mrp_pkg::rnd_shift(AW'(r4_av[i]), CB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_E+3]) begin
            for (int i = 0; i < 3; i++) begin
                r5_bt[i] <= n_bt[i][BTW-1:0];
                r5_ta[i] <= n_ta[i][61:0];
                r5_cx[i] <= (88'(r4_cxh[i]) <<< 26) + 88'(r4_cxl[i]);
            end
            r5_p <= r4_p;
        end
    end

    // back stage 4: B*t times the dot product in halves, round the cross term
    logic signed [AW-1:0]   n_tc [3];
    logic signed [BPLW-1:0] r6_bpl [3];
    logic signed [BPHW-1:0] r6_bph [3];
    logic signed [61:0]     r6_ta [3];
    logic signed [61:0]     r6_tc [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_tc[i] = mrp_pkg::rnd_shift(AW'(r5_cx[i]), CB + FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_E+4]) begin
            for (int i = 0; i < 3; i++) begin
                r6_bpl[i] <= BPLW'(r5_bt[i]) * BPLW'($signed({1'b0, r5_p[25:0]}));
                r6_bph[i] <= BPHW'(r5_bt[i]) * BPHW'($signed(r5_p[51:26]));
                r6_tc[i]  <= n_tc[i][61:0];
            end
            r6_ta <= r5_ta;
        end
    end

    // back stage 5: join the dot product halves
    logic signed [BPW-1:0] r7_bp [3];
    logic signed [61:0]    r7_ta [3];
    logic signed [61:0]    r7_tc [3];

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_E+5]) begin
            for (int i = 0; i < 3; i++) begin
                r7_bp[i] <= (BPW'(r6_bph[i]) <<< 26) + BPW'(r6_bpl[i]);
            end
            r7_ta <= r6_ta;
            r7_tc <= r6_tc;
        end
    end

    // back stage 6: round, sum the three terms, saturate into the output register
    logic signed [AW-1:0] n_tb  [3];
    logic signed [63:0]   n_sum [3];
    logic signed [VW-1:0] r8_out [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_tb[i]  = mrp_pkg::rnd_shift(AW'(r7_bp[i]), CB + FRAC_BITS);
            n_sum[i] = 64'(r7_ta[i]) + 64'($signed(n_tb[i][61:0])) + 64'(r7_tc[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[NS-1]) begin
            for (int i = 0; i < 3; i++) begin
                r8_out[i] <= mrp_pkg::sat32(n_sum[i]);
            end
        end
    end

    assign o_out_x = r8_out[0];
    assign o_out_y = r8_out[1];
    assign o_out_z = r8_out[2];

endmodule

### sv/mrp_div.sv
// pipelined restoring divider, one quotient bit per stage, with side payload
module mrp_div #(
    parameter int PW = 1
) (
    input  logic                      i_clk,
    input  logic [mrp_pkg::Q_W-1:0]   i_en,
    input  logic [mrp_pkg::DEN_W-1:0] i_den,
    input  logic [mrp_pkg::DEN_W-1:0] i_rem,
    input  logic [mrp_pkg::Q_W-1:0]   i_nlow,
    input  logic [PW-1:0]             i_pay,
    output logic [mrp_pkg::Q_W-1:0]   o_quo,
    output logic [PW-1:0]             o_pay
);

    localparam int NQ = mrp_pkg::Q_W;
    localparam int DW = mrp_pkg::DEN_W;

    logic [DW-1:0] r_den  [NQ];
    logic [DW-1:0] r_rem  [NQ];
    logic [NQ-1:0] r_nlow [NQ];
    logic [NQ-1:0] r_quo  [NQ];
    logic [PW-1:0] r_pay  [NQ];

    for (genvar k = 0; k < NQ; k++) begin : g_stage
        logic [DW-1:0] den_in;
        logic [DW-1:0] rem_in;
        logic [NQ-1:0] nlow_in;
        logic [NQ-1:0] quo_in;
        logic [PW-1:0] pay_in;
        logic [DW:0]   trial;
        logic          ge;

        // stage inputs from the ports or the previous stage
        if (k == 0) begin : g_first
            assign den_in  = i_den;
            assign rem_in  = i_rem;
            assign nlow_in = i_nlow;
            assign quo_in  = '0;
            assign pay_in  = i_pay;
        end else begin : g_next
            assign den_in  = r_den[k-1];
            assign rem_in  = r_rem[k-1];
            assign nlow_in = r_nlow[k-1];
            assign quo_in  = r_quo[k-1];
            assign pay_in  = r_pay[k-1];
        end

        // bring down one numerator bit and try the subtract
        always_comb begin
            trial = {rem_in, nlow_in[NQ-1]};
            ge    = (trial >= {1'b0, den_in});
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_den[k]  <= den_in;
                r_rem[k]  <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
                r_nlow[k] <= {nlow_in[NQ-2:0], 1'b0};
                r_quo[k]  <= {quo_in[NQ-2:0], ge};
                r_pay[k]  <= pay_in;
            end
        end
    end

    assign o_quo = r_quo[NQ-1];
    assign o_pay = r_pay[NQ-1];

endmodule

### sv/mrp_chk.sv
// port-level checks for the vector rotation unit, bound to the top level
module mrp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_out_x,
    input logic [31:0] o_out_y,
    input logic [31:0] o_out_z
);

    // input only stalls when the whole pipe is full behind a stalled output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked output");

    // a draining output frees the input side in the same cycle
    a_drain_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |-> !o_in_stall)
        else $error("input stalled while output drains");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat after reset");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z)))
        else $error("stalled output beat changed");

endmodule

bind mrp_vector_rotation_unit mrp_chk u_mrp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_x     (o_out_x),
    .o_out_y     (o_out_y),
    .o_out_z     (o_out_z)
);

### test/mrp_vector_rotation_unit_test.sv
// testbench for the vector rotation unit: random and directed beats checked against a predictor
`timescale 1ns / 1ps

module mrp_vector_rotation_unit_test;

    localparam int FB = mrp_pkg::FRAC_BITS_DEF;
    localparam int RW = mrp_pkg::ROT_W;
    localparam int VW = mrp_pkg::VEC_W;
    localparam int CB = mrp_pkg::COEF_BITS;

    typedef struct {
        logic signed [RW-1:0] rot [3];
        logic signed [VW-1:0] vec [3];
    } t_rot_item;

    typedef struct {
        logic signed [VW-1:0] res [3];
    } t_rot_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [RW-1:0] i_rot_x = '0, i_rot_y = '0, i_rot_z = '0;
    logic signed [VW-1:0] i_vec_x = '0, i_vec_y = '0, i_vec_z = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b1;
    logic signed [VW-1:0] o_out_x, o_out_y, o_out_z;

    t_rot_item   pending_beats [$];
    t_rot_result rotated_expected [$];
    int          fail_count = 0;
    int          cycle_count = 0;

    mrp_vector_rotation_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rot_x    (i_rot_x),
        .i_rot_y    (i_rot_y),
        .i_rot_z    (i_rot_z),
        .i_vec_x    (i_vec_x),
        .i_vec_y    (i_vec_y),
        .i_vec_z    (i_vec_z),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_out_z    (o_out_z)
    );

    // clock
    always #6 i_clk = ~i_clk;

    // rounded a*b / 2^k, ties away from zero, magnitude clipped to 2^60
    function automatic longint scaled_product(input longint a, input longint b, input int k);
        logic signed [127:0] p;
        logic [127:0] mag;
        logic neg;
        p = 128'(signed'(a)) * 128'(signed'(b));
        neg = p[127];
        mag = neg ? -p : p;
        mag = (mag + (128'd1 << (k - 1))) >> k;
        if (mag > (128'd1 << 60)) mag = 128'd1 << 60;
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    // rotation of v by the modified Rodrigues vector t
    function automatic t_rot_result rotate_vector(input t_rot_item it);
        t_rot_result r;
        longint t [3];
        longint v [3];
        longint cr [3];
        longint dot, a_c, c_c, b_c, w_c, w2, bt, sum;
        logic [63:0] s_sq, den;
        for (int i = 0; i < 3; i++) begin
            t[i] = longint'(it.rot[i]);
            v[i] = longint'(it.vec[i]);
        end
        s_sq = t[0] * t[0] + t[1] * t[1] + t[2] * t[2];
        if (2 * FB <= 32) s_sq = s_sq << (32 - 2 * FB);
        else s_sq = (s_sq + (64'd1 << (2 * FB - 33))) >> (2 * FB - 32);
        den = (64'd1 << 32) + s_sq;
        w_c = longint'(((64'd1 << 62) + den / 2) / den);
        w2 = longint'((64'(w_c * w_c) + (64'd1 << (CB - 1))) >> CB);
        a_c = 8 * w2 - 8 * w_c + (longint'(1) << CB);
        c_c = 8 * w2 - 4 * w_c;
        b_c = 8 * w2;
        dot = t[0] * v[0] + t[1] * v[1] + t[2] * v[2];
        cr[0] = t[1] * v[2] - t[2] * v[1];
        cr[1] = t[2] * v[0] - t[0] * v[2];
        cr[2] = t[0] * v[1] - t[1] * v[0];
        for (int i = 0; i < 3; i++) begin
            bt = scaled_product(b_c, t[i], FB);
            sum = scaled_product(a_c, v[i], CB)
                + scaled_product(bt, dot, CB + FB)
                + scaled_product(c_c, cr[i], CB + FB);
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            r.res[i] = sum[31:0];
        end
        return r;
    endfunction

    // random rotation component: mostly small angles, sometimes full range
    function automatic logic signed [RW-1:0] random_rot();
        case ($urandom_range(0, 3))
            0: return RW'($urandom);
            1: return RW'($urandom_range(0, 2 ** 17) - 2 ** 16);
            2: return RW'($urandom_range(0, 2 ** 13) - 2 ** 12);
            default: return RW'($urandom_range(0, 2 ** 15) - 2 ** 14);
        endcase
    endfunction

    // random vector component: full range or moderate size
    function automatic logic signed [VW-1:0] random_vec();
        case ($urandom_range(0, 2))
            0: return VW'($urandom);
            1: return VW'(signed'($urandom) >>> 8);
            default: return VW'(signed'($urandom) >>> 16);
        endcase
    endfunction

    function automatic t_rot_item make_item(input longint rx, input longint ry, input longint rz,
                                            input longint vx, input longint vy, input longint vz);
        t_rot_item it;
        it.rot[0] = RW'(rx); it.rot[1] = RW'(ry); it.rot[2] = RW'(rz);
        it.vec[0] = VW'(vx); it.vec[1] = VW'(vy); it.vec[2] = VW'(vz);
        return it;
    endfunction

    // stimulus
    initial begin
        t_rot_item it;
        // zero rotation, extremes of both fields, saturation
        pending_beats.push_back(make_item(0, 0, 0, 65536, -65536, 12345));
        pending_beats.push_back(make_item(0, 0, 0, 2147483647, -2147483648, 0));
        pending_beats.push_back(make_item(131071, 131071, 131071,
                                          2147483647, 2147483647, 2147483647));
        pending_beats.push_back(make_item(-131072, -131072, -131072,
                                          -2147483648, -2147483648, -2147483648));
        pending_beats.push_back(make_item(131071, -131072, 0, 2147483647, -2147483648, 1));
        pending_beats.push_back(make_item(65536, 0, 0, 0, 2147483647, 0));
        pending_beats.push_back(make_item(0, 65536, 0, 2147483647, 0, -2147483648));
        pending_beats.push_back(make_item(0, 0, -65536, 2147483647, 2147483647, 0));
        pending_beats.push_back(make_item(27146, 0, 0, 0, 65536, 0));
        pending_beats.push_back(make_item(0, 0, 131071, -2147483648, 2147483647, -1));
        pending_beats.push_back(make_item(1, -1, 1, -1, 1, -1));
        pending_beats.push_back(make_item(-131072, 0, 0, 0, 0, 2147483647));
        for (int n = 0; n < 1500; n++) begin
            for (int i = 0; i < 3; i++) begin
                it.rot[i] = random_rot();
                it.vec[i] = random_vec();
            end
            pending_beats.push_back(it);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_beats.size() == 0 && !i_in_valid && rotated_expected.size() == 0);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && rotated_expected.size() == 0) begin
            $display("** mrp_vector_rotation_unit: PASSED **");
        end else begin
            $display("** mrp_vector_rotation_unit: FAILED **");
        end
        $finish;
    end

    // timeout
    initial begin
        #5ms;
        $display("** mrp_vector_rotation_unit: FAILED **");
        $finish;
    end

    // driver: bursts of beats separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_rot_item it;
        t_rot_item cur;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                cur = make_item(i_rot_x, i_rot_y, i_rot_z, i_vec_x, i_vec_y, i_vec_z);
                rotated_expected.push_back(rotate_vector(cur));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    it = pending_beats.pop_front();
                    i_rot_x <= it.rot[0]; i_rot_y <= it.rot[1]; i_rot_z <= it.rot[2];
                    i_vec_x <= it.vec[0]; i_vec_y <= it.vec[1]; i_vec_z <= it.vec[2];
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 60);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off to fill the pipeline
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b1;
        end else if (cycle_count >= 400 && cycle_count < 600) begin
            i_out_stall <= 1'b1;
        end else begin
            case ((cycle_count / 300) % 3)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // monitor: compare each output beat with the oldest expectation
    always @(posedge i_clk) begin
        t_rot_result exp_r;
        logic signed [VW-1:0] got [3];
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got[0] = o_out_x; got[1] = o_out_y; got[2] = o_out_z;
            if (rotated_expected.size() == 0) begin
                $display("%0t: expected no beat, actual x=%0d y=%0d z=%0d",
                         $time, o_out_x, o_out_y, o_out_z);
                fail_count = fail_count + 1;
            end else begin
                exp_r = rotated_expected.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (got[i] !== exp_r.res[i]) begin
                        $display("%0t: component %0d expected %0d actual %0d",
                                 $time, i, exp_r.res[i], got[i]);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### filelist.f
sv/mrp_pkg.sv
sv/mrp_div.sv
sv/mrp_vector_rotation_unit.sv
sv/mrp_chk.sv
test/mrp_vector_rotation_unit_test.sv
